>>> src/selective_repeat_sender_window_defines.svh
// assertion macros for the selective-repeat sender window rtl, used in srsw_dp
// expects clk and rst_n in the scope where a macro is used
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SRSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SRSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/srsw_pkg.sv
// shared types, codes and constants of the selective-repeat sender window
// no dependencies
`default_nettype none

package srsw_pkg;

  localparam int WINDOW_LIMIT_DEF = 32;
  localparam int SEQ_BITS_DEF     = 32;

  localparam int WS_W       = 6;
  localparam int TOTAL_W    = 32;
  localparam int LIMIT_W    = 2;
  localparam int BITMAP_W   = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  // window end can reach total_chunks + 1 or base + window, never wraps
  localparam int STOP_W     = TOTAL_W + 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CHUNKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 2'd2;

  localparam logic [WS_W-1:0]    WS_RESET    = 6'd1;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 2'd3;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_FAIL   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_DONE = 2'd2,
    PH_FAIL = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DECODE = 3'd1,
    ST_ACKCHK = 3'd2,
    ST_SETUP  = 3'd3,
    ST_BUILD  = 3'd4,
    ST_WALK   = 3'd5,
    ST_SINGLE = 3'd6
  } state_t;

  typedef struct packed {
    logic latch;
    logic ack_upd;
    logic tmo_upd;
    logic setup;
    logic build;
    logic walk_step;
    logic push_walk;
    logic push_single;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       in_wait;
    logic       round_over;
    logic       past_end;
    logic       walk_emit;
    logic       walk_final;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> src/srsw_dp.sv
// datapath: config registers, window state, slot mask walker, output register
// depends on srsw_pkg and selective_repeat_sender_window_defines.svh
`default_nettype none
`include "selective_repeat_sender_window_defines.svh"

module srsw_dp #(
  parameter int WINDOW_LIMIT = srsw_pkg::WINDOW_LIMIT_DEF,
  parameter int SEQ_BITS     = srsw_pkg::SEQ_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [1:0]                       in_cmd,
  input  logic [SEQ_BITS-1:0]              in_ack_seq,
  input  logic [srsw_pkg::BITMAP_W-1:0]    in_ack_bitmap,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [1:0]                       out_kind,
  output logic [SEQ_BITS-1:0]              out_seq_num,
  output logic                             out_last,
  input  srsw_pkg::dp_cmd_t                cmd,
  output srsw_pkg::dp_stat_t               stat
);
  import srsw_pkg::*;

  localparam logic [WS_W-1:0] WL_V = WS_W'(WINDOW_LIMIT);

  logic [WS_W-1:0]    ws_r;
  logic [TOTAL_W-1:0] total_r;
  logic [LIMIT_W-1:0] limit_r;

  logic [1:0]          cmd_r;
  logic [SEQ_BITS-1:0] ack_seq_r;
  logic [BITMAP_W-1:0] ack_bitmap_r;

  logic [SEQ_BITS-1:0]     base_r, base_nxt;
  logic [BITMAP_W-1:0]     sack_r, sack_nxt;
  logic [SEQ_BITS-1:0]     round_end_r, round_end_nxt;
  logic [SEQ_BITS-1:0]     last_sent_r, last_sent_nxt;
  logic [LIMIT_W-1:0]      retry_r, retry_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [STOP_W-1:0]       stop_r, stop_nxt;
  logic [WINDOW_LIMIT-1:0] mask_r, mask_nxt;
  logic [SEQ_BITS-1:0]     walk_seq_r, walk_seq_nxt;
  kind_t                   pend_r, pend_nxt;

  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [SEQ_BITS-1:0] out_seq_r, out_seq_nxt;
  logic                out_last_r, out_last_nxt;

  logic [WS_W-1:0]         ws_eff;
  logic [STOP_W-1:0]       base_ext, total_ext, sum, lim, stop_val;
  logic                    past_end;
  logic [WS_W-1:0]         cnt;
  logic [WINDOW_LIMIT-1:0] mask_new;
  logic                    ack_take;
  logic [LIMIT_W-1:0]      retry_inc;
  logic                    walk_final;
  logic                    out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r    <= WS_RESET;
      total_r <= TOTAL_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_SIZE:  ws_r    <= cfg_data[WS_W-1:0];
        CFG_TOTAL_CHUNKS: total_r <= cfg_data[TOTAL_W-1:0];
        CFG_RETRY_LIMIT:  limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r        <= in_cmd;
      ack_seq_r    <= in_ack_seq;
      ack_bitmap_r <= in_ack_bitmap;
    end
  end

  // zero acts as one slot, oversize clips to the window limit
  assign ws_eff = (ws_r == '0) ? WS_W'(1) : ((ws_r > WL_V) ? WL_V : ws_r);

  assign base_ext  = STOP_W'(base_r);
  assign total_ext = STOP_W'(total_r);
  assign past_end  = base_ext > total_ext;
  assign sum       = base_ext + STOP_W'(ws_eff);
  assign lim       = total_ext + STOP_W'(1);
  assign stop_val  = (sum > lim) ? lim : sum;

  assign cnt = WS_W'(stop_r - base_ext);

  // base slot always goes out, later slots up to the window end unless already acked
  assign mask_new[0] = 1'b1;
  for (genvar g = 1; g < WINDOW_LIMIT; g++) begin : g_mask
    assign mask_new[g] = (cnt > WS_W'(g)) && !sack_r[g-1];
  end

  assign ack_take   = (ack_seq_r > base_r) || (|(ack_bitmap_r & ~sack_r));
  assign retry_inc  = retry_r + LIMIT_W'(1);
  assign walk_final = (mask_r >> 1) == '0;
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    base_nxt      = base_r;
    sack_nxt      = sack_r;
    round_end_nxt = round_end_r;
    last_sent_nxt = last_sent_r;
    retry_nxt     = retry_r;
    phase_nxt     = phase_r;
    stop_nxt      = stop_r;
    mask_nxt      = mask_r;
    walk_seq_nxt  = walk_seq_r;
    pend_nxt      = pend_r;

    if (cmd.ack_upd && ack_take) begin
      base_nxt = ack_seq_r;
      sack_nxt = ack_bitmap_r;
    end
    if (cmd.tmo_upd) begin
      retry_nxt = retry_inc;
      if (retry_inc < limit_r) begin
        pend_nxt = KIND_RESEND;
      end else begin
        pend_nxt  = KIND_FAIL;
        phase_nxt = PH_FAIL;
      end
    end
    if (cmd.setup) begin
      retry_nxt = '0;
      if (past_end) begin
        phase_nxt = PH_DONE;
        pend_nxt  = KIND_DONE;
      end else begin
        stop_nxt      = stop_val;
        round_end_nxt = stop_val[SEQ_BITS-1:0];
      end
    end
    if (cmd.build) begin
      mask_nxt     = mask_new;
      walk_seq_nxt = base_r;
      phase_nxt    = PH_WAIT;
    end
    if (cmd.walk_step) begin
      mask_nxt     = mask_r >> 1;
      walk_seq_nxt = walk_seq_r + SEQ_BITS'(1);
      if (cmd.push_walk) begin
        last_sent_nxt = walk_seq_r;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_seq_nxt   = out_seq_r;
    out_last_nxt  = out_last_r;
    if (cmd.push_walk) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_SEND;
      out_seq_nxt   = walk_seq_r;
      out_last_nxt  = walk_final;
    end else if (cmd.push_single) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = pend_r;
      out_seq_nxt   = (pend_r == KIND_RESEND) ? last_sent_r : '0;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= SEQ_BITS'(1);
      sack_r      <= '0;
      round_end_r <= SEQ_BITS'(1);
      last_sent_r <= '0;
      retry_r     <= '0;
      phase_r     <= PH_IDLE;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      sack_r      <= sack_nxt;
      round_end_r <= round_end_nxt;
      last_sent_r <= last_sent_nxt;
      retry_r     <= retry_nxt;
      phase_r     <= phase_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stop_r     <= stop_nxt;
    walk_seq_r <= walk_seq_nxt;
    pend_r     <= pend_nxt;
    out_kind_r <= out_kind_nxt;
    out_seq_r  <= out_seq_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_seq_num = out_seq_r;
  assign out_last    = out_last_r;

  assign stat.cmd        = cmd_r;
  assign stat.in_wait    = (phase_r == PH_WAIT);
  assign stat.round_over = (base_r >= round_end_r);
  assign stat.past_end   = past_end;
  assign stat.walk_emit  = mask_r[0];
  assign stat.walk_final = walk_final;
  assign stat.out_free   = out_free;

  `SRSW_ASSERT_NOW(a_push_room, cmd.push_walk || cmd.push_single, out_free, "result pushed over a pending transfer")
  `SRSW_ASSERT_NOW(a_push_excl, 1'b1, $onehot0({cmd.push_walk, cmd.push_single}), "two result sources at once")
  `SRSW_ASSERT_NEXT(a_build_base, cmd.build, mask_r[0] && (phase_r == PH_WAIT), "round built without base slot")
  `SRSW_ASSERT_NOW(a_walk_slot, cmd.push_walk, mask_r[0] && cmd.walk_step, "send pushed for a skipped slot")

endmodule

`default_nettype wire

>>> src/srsw_ctrl.sv
// controller state machine: sequences decode, ack check, round setup, the slot walk and single results
// depends on srsw_pkg
`default_nettype none

module srsw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  srsw_pkg::dp_stat_t stat,
  output srsw_pkg::dp_cmd_t  cmd
);
  import srsw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.cmd)
          CMD_START: state_nxt = ST_SETUP;
          CMD_ACK: begin
            if (stat.in_wait) begin
              cmd.ack_upd = 1'b1;
              state_nxt   = ST_ACKCHK;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          CMD_TIMEOUT: begin
            if (stat.in_wait) begin
              cmd.tmo_upd = 1'b1;
              state_nxt   = ST_SINGLE;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_ACKCHK: begin
        state_nxt = stat.round_over ? ST_SETUP : ST_IDLE;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = stat.past_end ? ST_SINGLE : ST_BUILD;
      end
      ST_BUILD: begin
        cmd.build = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        // acked slots step past without needing the output register
        if (!stat.walk_emit || stat.out_free) begin
          cmd.walk_step = 1'b1;
          cmd.push_walk = stat.walk_emit;
          if (stat.walk_final) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SINGLE: begin
        if (stat.out_free) begin
          cmd.push_single = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> src/selective_repeat_sender_window.sv
// Selective-repeat ARQ sender window. An event is taken only while the block
// is idle. A start, or an ack that completes the round, goes through decode
// and round setup (an ack also through the ack check), builds the slot mask
// and then walks the window one slot per cycle, holding on a slot to be sent
// while the output is stalled, and issues one send transfer for every slot up
// to the window end not marked in the ack bitmap. A round set up past the last
// chunk goes from setup to its done result. An ack that does not finish the
// round returns to idle with no result; a timeout in the wait phase gives its
// single result. The output register lets the last result of an event wait
// while the next event is accepted.
// top level: srsw_ctrl and srsw_dp, types from srsw_pkg
`default_nettype none

module selective_repeat_sender_window #(
  parameter int WINDOW_LIMIT = srsw_pkg::WINDOW_LIMIT_DEF,
  parameter int SEQ_BITS     = srsw_pkg::SEQ_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_cmd,
  input  logic [SEQ_BITS-1:0]             in_ack_seq,
  input  logic [srsw_pkg::BITMAP_W-1:0]   in_ack_bitmap,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_kind,
  output logic [SEQ_BITS-1:0]             out_seq_num,
  output logic                            out_last
);
  import srsw_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  srsw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  srsw_dp #(
    .WINDOW_LIMIT (WINDOW_LIMIT),
    .SEQ_BITS     (SEQ_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_cmd        (in_cmd),
    .in_ack_seq    (in_ack_seq),
    .in_ack_bitmap (in_ack_bitmap),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_seq_num   (out_seq_num),
    .out_last      (out_last),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

`default_nettype wire
